>>> hw/rtl/jetp_pkg.sv
package jetp_pkg;

  // frame geometry and iteration cap
  localparam int unsigned FRAME_WIDTH  = 1000;
  localparam int unsigned FRAME_HEIGHT = 500;
  localparam int unsigned MAX_ITER     = 256;

  localparam int unsigned PX_W    = 10;
  localparam int unsigned PY_W    = 9;
  localparam int unsigned ZOOM_W  = 16;
  localparam int unsigned LIMIT_W = 9;
  localparam int unsigned COUNT_W = 9;
  localparam int unsigned Q_FRAC  = 28;

  // the limit register is 9 bits wide, so the cap never exceeds 511
  localparam int unsigned LIM_CAP = (MAX_ITER > 511) ? 511 : MAX_ITER;
  // iterations done plus one, up to 512
  localparam int unsigned CNT_W   = 10;

  // pixel offset from the frame centre, frames up to 8192 wide
  localparam int unsigned DX_W    = 13;
  // magnitude of 3*dx or 2*dy
  localparam int unsigned NUMM_W  = 14;
  localparam int unsigned NUM_W   = NUMM_W + Q_FRAC;
  // zoom times frame size
  localparam int unsigned DEN_W   = ZOOM_W + DX_W;

  localparam logic [31:0] COLOUR_STEP = 32'h0001_01DF;
  localparam logic [63:0] MAG_LIMIT   = 64'h1 << (2 * Q_FRAC + 2);

  typedef enum logic [2:0] {
    REG_C_REAL      = 3'd0,
    REG_C_IMAG      = 3'd1,
    REG_ZOOM_LEVEL  = 3'd2,
    REG_CENTER_REAL = 3'd3,
    REG_CENTER_IMAG = 3'd4,
    REG_ITER_LIMIT  = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [PX_W-1:0] pixel_x;
    logic [PY_W-1:0] pixel_y;
  } pixel_req_t;

  typedef struct packed {
    logic [COUNT_W-1:0] escape_count;
    logic [31:0]        pixel_colour;
    logic               escaped;
  } pixel_res_t;

  function automatic logic signed [31:0] sat_s32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/jetp_div.sv
module jetp_div #(
  parameter int unsigned NUM_W = jetp_pkg::NUM_W,
  parameter int unsigned DEN_W = jetp_pkg::DEN_W
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] dividend_i,
  input  logic [DEN_W-1:0] divisor_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quotient_o
);
  import jetp_pkg::*;

  localparam int unsigned STEP_W = $clog2(NUM_W);

  logic              busy_q;
  logic              done_q;
  logic [STEP_W-1:0] step_q;
  logic [NUM_W-1:0]  quo_q;
  logic [DEN_W-1:0]  rem_q;
  logic [DEN_W-1:0]  dvs_q;

  logic [DEN_W:0]    rem_sh;
  logic              fits;
  logic [DEN_W:0]    rem_nx;

  // restoring division, one quotient bit per cycle
  always_comb begin
    rem_sh = {rem_q, quo_q[NUM_W-1]};
    fits   = rem_sh >= {1'b0, dvs_q};
    rem_nx = fits ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + STEP_W'(1);
        if (step_q == STEP_W'(NUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[NUM_W-2:0], fits};
      rem_q <= rem_nx[DEN_W-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

>>> hw/rtl/julia_escape_time_pixel_top.sv
// Julia set escape-time pixel. Pulse start with a pixel coordinate while busy is low;
// busy falls in the cycle the result is shown. The start point is found by two
// restoring dividers working side by side, one quotient bit a cycle, then each
// z = z^2 + c step runs through the phases P0, P1 and P2 on a single shared 32x32
// multiplier (re*re, im*im, re*im), and one more multiplier pass forms the colour.
// The result stands on result_o for exactly one cycle, flagged by result_valid_o,
// and cannot be held off: the receiver must take it in that cycle. Configuration writes
// are taken at any time (cfg_ready_o is always high) but belong in idle periods only.
module julia_escape_time_pixel_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  jetp_pkg::pixel_req_t in_i,
  output logic                result_valid_o,
  output jetp_pkg::pixel_res_t result_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i
);
  import jetp_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_MAP    = 3'd1;
  localparam logic [2:0] ST_P0     = 3'd2;
  localparam logic [2:0] ST_P1     = 3'd3;
  localparam logic [2:0] ST_P2     = 3'd4;
  localparam logic [2:0] ST_COLOUR = 3'd5;

  // configuration
  logic signed [31:0]  c_real_q, c_imag_q, center_real_q, center_imag_q;
  logic [ZOOM_W-1:0]   zoom_q;
  logic [LIMIT_W-1:0]  limit_q;

  // control
  logic [2:0]          state_q;
  logic                first_q;
  logic                esc_q;
  logic                valid_q;
  logic                re_neg_q, im_neg_q;
  logic [CNT_W-1:0]    count_q;

  // datapath
  logic signed [31:0]  re_q, im_q;
  logic signed [63:0]  prod_q, rr_q;
  pixel_res_t          res_q;

  logic                accept;
  logic [ZOOM_W-1:0]   zoom_eff;
  logic signed [DX_W-1:0] dx, dy;
  logic [DX_W-1:0]     dx_abs, dy_abs;
  logic [NUMM_W-1:0]   num_re_mag, num_im_mag;
  logic [DEN_W-1:0]    den_re, den_im;
  logic                re_done, im_done;
  logic [NUM_W-1:0]    re_quo, im_quo;
  logic signed [63:0]  q_re64, q_im64, map_re64, map_im64;

  logic signed [31:0]  mul_a, mul_b;
  logic signed [63:0]  mul_p;
  logic signed [63:0]  diff64, nre64, nim64;
  logic [63:0]         mag_sum;
  logic                outside;
  logic [CNT_W-1:0]    lim;
  logic [CNT_W-1:0]    count_inc;

  assign accept      = start && !busy;
  assign busy        = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;

  // pixel to plane mapping operands
  always_comb begin
    zoom_eff   = (zoom_q == '0) ? ZOOM_W'(1) : zoom_q;
    dx         = $signed({{(DX_W-PX_W){1'b0}}, in_i.pixel_x}) - DX_W'(FRAME_WIDTH / 2);
    dy         = $signed({{(DX_W-PY_W){1'b0}}, in_i.pixel_y}) - DX_W'(FRAME_HEIGHT / 2);
    dx_abs     = dx[DX_W-1] ? DX_W'(-dx) : DX_W'(dx);
    dy_abs     = dy[DX_W-1] ? DX_W'(-dy) : DX_W'(dy);
    num_re_mag = NUMM_W'({dx_abs, 1'b0}) + NUMM_W'(dx_abs);
    num_im_mag = NUMM_W'({dy_abs, 1'b0});
    den_re     = DEN_W'(zoom_eff) * DEN_W'(FRAME_WIDTH);
    den_im     = DEN_W'(zoom_eff) * DEN_W'(FRAME_HEIGHT);
  end

  jetp_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div_re (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept),
    .dividend_i ({num_re_mag, {Q_FRAC{1'b0}}}),
    .divisor_i  (den_re),
    .done_o     (re_done),
    .quotient_o (re_quo)
  );

  jetp_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div_im (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept),
    .dividend_i ({num_im_mag, {Q_FRAC{1'b0}}}),
    .divisor_i  (den_im),
    .done_o     (im_done),
    .quotient_o (im_quo)
  );

  // quotient truncates toward zero, then the centre offset is added
  always_comb begin
    q_re64   = $signed({{(64-NUM_W){1'b0}}, re_quo});
    q_im64   = $signed({{(64-NUM_W){1'b0}}, im_quo});
    map_re64 = (re_neg_q ? -q_re64 : q_re64) + {{32{center_real_q[31]}}, center_real_q};
    map_im64 = (im_neg_q ? -q_im64 : q_im64) + {{32{center_imag_q[31]}}, center_imag_q};
  end

  // shared multiplier
  always_comb begin
    count_inc = count_q + CNT_W'(1);
    case (state_q)
      ST_P1: begin
        mul_a = im_q;
        mul_b = im_q;
      end
      ST_P2: begin
        mul_a = re_q;
        mul_b = im_q;
      end
      ST_COLOUR: begin
        mul_a = $signed(COLOUR_STEP);
        mul_b = $signed({{(32-CNT_W){1'b0}}, count_inc});
      end
      default: begin
        mul_a = re_q;
        mul_b = re_q;
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  // in P2 prod_q holds im^2 and rr_q holds re^2; in P0 prod_q holds re*im
  always_comb begin
    diff64  = rr_q - prod_q;
    mag_sum = $unsigned(rr_q) + $unsigned(prod_q);
    outside = mag_sum > MAG_LIMIT;
    nre64   = (diff64 >>> Q_FRAC) + $signed({{32{c_real_q[31]}}, c_real_q});
    nim64   = (prod_q >>> (Q_FRAC - 1)) + $signed({{32{c_imag_q[31]}}, c_imag_q});
    lim     = ({1'b0, limit_q} > CNT_W'(LIM_CAP)) ? CNT_W'(LIM_CAP) : {1'b0, limit_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_real_q      <= '0;
      c_imag_q      <= '0;
      zoom_q        <= ZOOM_W'(1);
      center_real_q <= '0;
      center_imag_q <= '0;
      limit_q       <= LIMIT_W'(64);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_C_REAL:      c_real_q      <= cfg_data_i;
        REG_C_IMAG:      c_imag_q      <= cfg_data_i;
        REG_ZOOM_LEVEL:  zoom_q        <= cfg_data_i[ZOOM_W-1:0];
        REG_CENTER_REAL: center_real_q <= cfg_data_i;
        REG_CENTER_IMAG: center_imag_q <= cfg_data_i;
        REG_ITER_LIMIT:  limit_q       <= cfg_data_i[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      first_q  <= 1'b0;
      esc_q    <= 1'b0;
      valid_q  <= 1'b0;
      re_neg_q <= 1'b0;
      im_neg_q <= 1'b0;
    end else begin
      valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            re_neg_q <= dx[DX_W-1];
            im_neg_q <= dy[DX_W-1];
            state_q  <= ST_MAP;
          end
        end
        ST_MAP: begin
          if (re_done) begin
            first_q <= 1'b1;
            state_q <= ST_P0;
          end
        end
        ST_P0: begin
          first_q <= 1'b0;
          state_q <= ST_P1;
        end
        ST_P1: begin
          state_q <= ST_P2;
        end
        ST_P2: begin
          if (count_q >= lim) begin
            esc_q   <= 1'b0;
            state_q <= ST_COLOUR;
          end else if (outside) begin
            esc_q   <= 1'b1;
            state_q <= ST_COLOUR;
          end else begin
            state_q <= ST_P0;
          end
        end
        ST_COLOUR: begin
          valid_q <= 1'b1;
          state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_p;
    case (state_q)
      ST_IDLE: begin
        count_q <= '0;
      end
      ST_MAP: begin
        if (re_done) begin
          re_q <= sat_s32(map_re64);
          im_q <= sat_s32(map_im64);
        end
      end
      ST_P0: begin
        // imaginary part of the previous step lands here
        if (!first_q) begin
          im_q <= sat_s32(nim64);
        end
      end
      ST_P1: begin
        rr_q <= prod_q;
      end
      ST_P2: begin
        if (count_q < lim && !outside) begin
          re_q    <= sat_s32(nre64);
          count_q <= count_inc;
        end
      end
      ST_COLOUR: begin
        res_q.escape_count <= count_inc[COUNT_W-1:0];
        res_q.pixel_colour <= mul_p[31:0];
        res_q.escaped      <= esc_q;
      end
      default: ;
    endcase
  end

  assign result_valid_o = valid_q;
  assign result_o       = res_q;

`ifndef SYNTHESIS
  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe longer than one cycle");

  a_busy_after_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

  a_div_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    re_done == im_done)
    else $error("dividers out of step");

  a_phase_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_P1) |=> (state_q == ST_P2))
    else $error("iteration phase skipped");

  a_colour_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COLOUR) |=> (result_valid_o && !busy))
    else $error("colour pass not followed by result");
`endif

endmodule
